>>> rtl/pivot_bucket_partitioner_macros.svh
// Assertion macros shared by the pivot bucket partitioner RTL.
// Depends on nothing; included inside module bodies.
`ifndef PIVOT_BUCKET_PARTITIONER_MACROS_SVH
`define PIVOT_BUCKET_PARTITIONER_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define PBP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define PBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/pbp_pkg.sv
// Package for the pivot bucket partitioner: item kinds, register map, FSM states.
// No dependencies.
package pbp_pkg;

  localparam int unsigned ValW   = 64;
  localparam int unsigned IdxW   = 6;
  localparam int unsigned KindW  = 2;
  localparam int unsigned CountW = 6;
  localparam int unsigned LimitW = 7;
  localparam int unsigned AddrW  = 3;

  typedef enum logic [KindW-1:0] {
    KIND_LOAD     = 2'd0,
    KIND_CLASSIFY = 2'd1,
    KIND_FLUSH    = 2'd2,
    KIND_NONE     = 2'd3
  } kind_e;

  // Byte addresses of the configuration registers.
  localparam logic [AddrW-1:0] AddrPivotCount  = 3'd0;
  localparam logic [AddrW-1:0] AddrBufferLimit = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_APPEND,
    ST_WRITE,
    ST_FLUSH,
    ST_EMIT
  } state_e;

endpackage

>>> rtl/pbp_stream_if.sv
// Valid/ready channel interfaces for the input and result items.
// Depends on pbp_pkg for field widths.
interface pbp_in_if;
  logic                                ready;
  logic                                valid;
  logic [pbp_pkg::KindW-1:0]           kind;
  logic [pbp_pkg::IdxW-1:0]            index;
  logic signed [pbp_pkg::ValW-1:0]     value;
  modport source (output valid, kind, index, value, input ready);
  modport sink   (input valid, kind, index, value, output ready);
endinterface

interface pbp_out_if;
  logic                                ready;
  logic                                valid;
  logic [pbp_pkg::IdxW-1:0]            bucket;
  logic signed [pbp_pkg::ValW-1:0]     element;
  logic                                last_in_run;
  modport source (output valid, bucket, element, last_in_run, input ready);
  modport sink   (input valid, bucket, element, last_in_run, output ready);
endinterface

>>> rtl/pbp_cell.sv
// One classification cell: holds one pivot, compares the passing value and
// hands value and running count to its right neighbor. Depends on pbp_pkg.
module pbp_cell #(
  parameter int unsigned CntW = 7
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_i,
  input  logic [pbp_pkg::ValW-1:0]   pivot_i,
  input  logic                       enable_i,
  input  logic                       valid_i,
  input  logic [pbp_pkg::ValW-1:0]   value_i,
  input  logic [CntW-1:0]            count_i,
  output logic                       valid_o,
  output logic [pbp_pkg::ValW-1:0]   value_o,
  output logic [CntW-1:0]            count_o
);
  import pbp_pkg::*;

  logic [ValW-1:0] pivot_q;
  logic            valid_q;
  logic [ValW-1:0] value_q;
  logic [CntW-1:0] count_q, count_d;
  logic            le;

  // Pivot storage
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pivot_q <= pivot_i;
    end
  end

  // Signed compare via sign flip
  assign le      = (pivot_q ^ {1'b1, {(ValW-1){1'b0}}}) <= (value_i ^ {1'b1, {(ValW-1){1'b0}}});
  assign count_d = (enable_i && le) ? count_i + CntW'(1) : count_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_i;
    count_q <= count_d;
  end

  assign valid_o = valid_q;
  assign value_o = value_q;
  assign count_o = count_q;
endmodule

>>> rtl/pbp_chain.sv
// Row of pivot cells that computes the upper-bound bucket of a value.
// Depends on pbp_pkg and pbp_cell.
module pbp_chain #(
  parameter int unsigned NPiv = 63,
  parameter int unsigned CntW = 7
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  logic [CntW-1:0]           slot_i,
  input  logic [pbp_pkg::ValW-1:0]  pivot_i,
  input  logic [CntW-1:0]           used_i,
  input  logic                      valid_i,
  input  logic [pbp_pkg::ValW-1:0]  value_i,
  output logic                      valid_o,
  output logic [pbp_pkg::ValW-1:0]  value_o,
  output logic [CntW-1:0]           count_o
);
  import pbp_pkg::*;

  logic            vld [NPiv+1];
  logic [ValW-1:0] val [NPiv+1];
  logic [CntW-1:0] cnt [NPiv+1];

  assign vld[0] = valid_i;
  assign val[0] = value_i;
  assign cnt[0] = '0;

  // One cell per pivot slot
  for (genvar g = 0; g < NPiv; g++) begin : g_cell
    pbp_cell #(.CntW(CntW)) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .load_i   (load_i && (slot_i == CntW'(g))),
      .pivot_i  (pivot_i),
      .enable_i (CntW'(g) < used_i),
      .valid_i  (vld[g]),
      .value_i  (val[g]),
      .count_i  (cnt[g]),
      .valid_o  (vld[g+1]),
      .value_o  (val[g+1]),
      .count_o  (cnt[g+1])
    );
  end

  assign valid_o = vld[NPiv];
  assign value_o = val[NPiv];
  assign count_o = cnt[NPiv];
endmodule

>>> rtl/pivot_bucket_partitioner.sv
// Top level of the pivot bucket partitioner: APB registers, cell chain, bucket buffer
// memory and emit sequencer. Depends on pbp_pkg, pbp_stream_if, pbp_chain, macro header.
//
//  channel  dir  handshake        payload
//  in_if    in   valid/ready      kind, index, value
//  out_if   out  valid/ready      bucket, element, last_in_run
//  apb      in   psel/penable     paddr, pwdata -> pivot_count, buffer_limit
//
// A load leaves the input open. A classify keeps the input closed while the value
// walks the cell row and then for the append to its bucket buffer. A flush waits
// on the registered fill read. A buffer drains through the registered memory read,
// with at most one read in flight, and then closes.
// After reset a sweep through every bucket clears the fill counts.
// Output stalls hold the emit sequencer; no item is taken meanwhile.
module pivot_bucket_partitioner #(
  parameter int unsigned MAX_BUCKETS = 64,
  parameter int unsigned BUF_DEPTH   = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  pbp_in_if.sink                     in_if,
  pbp_out_if.source                  out_if,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pbp_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import pbp_pkg::*;
  `include "pivot_bucket_partitioner_macros.svh"

  localparam int unsigned NPiv  = MAX_BUCKETS - 1;
  localparam int unsigned BW    = $clog2(MAX_BUCKETS);
  localparam int unsigned CntW  = BW + 1;
  localparam int unsigned DW    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int unsigned FW    = $clog2(BUF_DEPTH + 1);
  localparam int unsigned Slots = MAX_BUCKETS << DW;

  // Registers
  logic [CountW-1:0] pivot_count_q;
  logic [LimitW-1:0] buffer_limit_q;
  logic              wr;
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pivot_count_q  <= '0;
      buffer_limit_q <= 7'd64;
    end else if (wr) begin
      if (paddr == AddrPivotCount) pivot_count_q <= pwdata[CountW-1:0];
      if (paddr == AddrBufferLimit) buffer_limit_q <= pwdata[LimitW-1:0];
    end
  end
  always_comb begin
    prdata = '0;
    if (paddr == AddrPivotCount) prdata = 32'(pivot_count_q);
    else if (paddr == AddrBufferLimit) prdata = 32'(buffer_limit_q);
  end

  // Effective pivot count and limit
  logic [CntW-1:0] used;
  logic [FW-1:0]   lim;
  assign used = (32'(pivot_count_q) > NPiv) ? CntW'(NPiv) : CntW'(pivot_count_q);
  always_comb begin
    if (buffer_limit_q == '0) lim = FW'(1);
    else if (32'(buffer_limit_q) > BUF_DEPTH) lim = FW'(BUF_DEPTH);
    else lim = FW'(buffer_limit_q);
  end

  // Control
  state_e          state_q, state_d;
  logic            accept;
  logic [BW-1:0]   sweep_q, sweep_d;
  logic [BW-1:0]   cur_q, cur_d;
  logic [FW-1:0]   n_q, n_d;
  logic [FW-1:0]   k_q, k_d;
  logic            rd_pend_q, rd_pend_d;
  logic            chain_in_v;
  logic            chain_v;
  logic [ValW-1:0] chain_val;
  logic [CntW-1:0] chain_cnt;
  logic [ValW-1:0] app_val_q;

  logic [FW-1:0]   fill_q [MAX_BUCKETS];
  logic            fill_we;
  logic [BW-1:0]   fill_wa;
  logic [FW-1:0]   fill_wd;
  logic [BW-1:0]   fill_ra;
  logic [FW-1:0]   fill_rd_q;

  logic            mem_we;
  logic [BW+DW-1:0] mem_wa, mem_ra;
  logic [ValW-1:0] mem_wd, mem_rd_q;
  logic [ValW-1:0] mem_q [Slots];
  logic            mem_re;

  logic            ovalid_q, ovalid_d;
  logic            olast_q, olast_d;
  logic            oload;

  assign in_if.ready = (state_q == ST_IDLE);
  assign accept = in_if.valid && in_if.ready;
  assign chain_in_v = accept && (kind_e'(in_if.kind) == KIND_CLASSIFY);

  pbp_chain #(.NPiv(NPiv), .CntW(CntW)) u_chain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (accept && (kind_e'(in_if.kind) == KIND_LOAD) && (32'(in_if.index) < NPiv)),
    .slot_i  (CntW'(in_if.index)),
    .pivot_i (in_if.value),
    .used_i  (used),
    .valid_i (chain_in_v),
    .value_i (in_if.value),
    .valid_o (chain_v),
    .value_o (chain_val),
    .count_o (chain_cnt)
  );

  assign mem_wd = app_val_q;

  always_comb begin
    state_d   = state_q;
    sweep_d   = sweep_q;
    cur_d     = cur_q;
    n_d       = n_q;
    k_d       = k_q;
    rd_pend_d = 1'b0;
    fill_we   = 1'b0;
    fill_wa   = cur_q;
    fill_wd   = '0;
    fill_ra   = cur_q;
    mem_we    = 1'b0;
    mem_wa    = {cur_q, fill_rd_q[DW-1:0]};
    mem_re    = 1'b0;
    mem_ra    = {cur_q, k_q[DW-1:0]};
    unique case (state_q)
      ST_SWEEP: begin
        fill_we = 1'b1;
        fill_wa = sweep_q;
        sweep_d = sweep_q + BW'(1);
        if (32'(sweep_q) == MAX_BUCKETS - 1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        fill_ra = BW'(in_if.index);
        if (accept) begin
          if (kind_e'(in_if.kind) == KIND_CLASSIFY) begin
            state_d = ST_APPEND;
          end else if (kind_e'(in_if.kind) == KIND_FLUSH &&
                       32'(in_if.index) < MAX_BUCKETS) begin
            cur_d   = BW'(in_if.index);
            state_d = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        // Fill count of the flushed bucket is now registered
        state_d = ST_IDLE;
        if (fill_rd_q != '0) begin
          n_d     = fill_rd_q;
          k_d     = '0;
          fill_we = 1'b1;
          state_d = ST_EMIT;
        end
      end
      ST_APPEND: begin
        // Read the fill count while the bucket leaves the last cell
        fill_ra = BW'(chain_cnt);
        if (chain_v) begin
          cur_d   = BW'(chain_cnt);
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        state_d = ST_IDLE;
        if (32'(fill_rd_q) < BUF_DEPTH) begin
          mem_we  = 1'b1;
          fill_we = 1'b1;
          fill_wd = fill_rd_q + FW'(1);
          if (fill_wd >= lim) begin
            fill_wd = '0;
            n_d     = fill_rd_q + FW'(1);
            k_d     = '0;
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        // Issue a read when the output slot will be free next cycle
        if (k_q < n_q && !rd_pend_q && (!ovalid_q || out_if.ready)) begin
          mem_re    = 1'b1;
          rd_pend_d = 1'b1;
          k_d       = k_q + FW'(1);
        end
        if (k_q == n_q && !rd_pend_q && (!ovalid_q || out_if.ready)) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign oload    = rd_pend_q;
  assign ovalid_d = oload ? 1'b1 : (ovalid_q && !out_if.ready);
  assign olast_d  = oload ? (k_q == n_q) : olast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_SWEEP;
      sweep_q   <= '0;
      rd_pend_q <= 1'b0;
      ovalid_q  <= 1'b0;
      olast_q   <= 1'b0;
      cur_q     <= '0;
      n_q       <= '0;
      k_q       <= '0;
    end else begin
      state_q   <= state_d;
      sweep_q   <= sweep_d;
      rd_pend_q <= rd_pend_d;
      ovalid_q  <= ovalid_d;
      olast_q   <= olast_d;
      cur_q     <= cur_d;
      n_q       <= n_d;
      k_q       <= k_d;
    end
  end

  // Classified value waiting for the append
  always_ff @(posedge clk_i) begin
    if (chain_v) begin
      app_val_q <= chain_val;
    end
  end

  // Fill counts, cleared by the sweep after reset; one registered read port
  always_ff @(posedge clk_i) begin
    if (fill_we) begin
      fill_q[fill_wa] <= fill_wd;
    end
    fill_rd_q <= fill_q[fill_ra];
  end

  // Bucket buffer memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_rd_q <= mem_q[mem_ra];
    end
  end

  // Output register
  logic [ValW-1:0] oelem_q;
  logic [BW-1:0]   obkt_q;
  always_ff @(posedge clk_i) begin
    if (oload) begin
      oelem_q <= mem_rd_q;
      obkt_q  <= cur_q;
    end
  end
  assign out_if.valid       = ovalid_q;
  assign out_if.element     = oelem_q;
  assign out_if.bucket      = IdxW'(obkt_q);
  assign out_if.last_in_run = olast_q;

  `PBP_ASSERT_IMPL(a_idle_no_out, clk_i, rst_ni, state_q == ST_IDLE, !rd_pend_q,
    "read pending while idle")
  `PBP_ASSERT_NEXT(a_hold, clk_i, rst_ni, ovalid_q && !out_if.ready && !oload,
    ovalid_q && $stable(oelem_q), "result dropped under stall")
  `PBP_ASSERT_IMPL(a_k_bound, clk_i, rst_ni, state_q == ST_EMIT, k_q <= n_q,
    "emit index past fill")
  `PBP_ASSERT_NEXT(a_pend_loads, clk_i, rst_ni, rd_pend_q, ovalid_q,
    "read data not loaded")
endmodule
